FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: rtl/bmm_pkg.sv
package bmm_pkg;
  localparam int DefMaxLeft  = 64;
  localparam int DefMaxRight = 64;
  localparam int RowW        = 64;
  localparam int RcW         = 7;
  localparam int MatchW      = 7;
  localparam int IndW        = 8;

  typedef struct packed {
    logic [RowW-1:0] row_bits;
    logic            last_row;
  } in_item_t;

  typedef struct packed {
    logic [MatchW-1:0] match_count;
    logic [IndW-1:0]   independent_count;
    logic              overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_START, S_RD, S_WAIT, S_SCAN, S_PUSH, S_POP, S_UNRD, S_UNWIND, S_DONE
  } bk_state_t;
endpackage

FILE: rtl/bmm_if.sv
interface bmm_in_if;
  import bmm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bmm_out_if;
  import bmm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bmm_ram.sv
module bmm_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/bmm_front.sv
`include "assert_macros.svh"
module bmm_front #(
  parameter int MaxLeft = bmm_pkg::DefMaxLeft
) (
  input  logic                           clk,
  input  logic                           rst,
  bmm_in_if.sink                         in_ch,
  output logic                           row_we,
  output logic [$clog2(MaxLeft)-1:0]     row_addr,
  output logic [bmm_pkg::RowW-1:0]       row_data,
  // job queue toward the back part: row count and overflow
  output logic                           job_valid,
  input  logic                           job_ready,
  output logic [$clog2(MaxLeft+1)-1:0]   job_rows,
  output logic                           job_ovf
);
  import bmm_pkg::*;
  localparam int CntW = $clog2(MaxLeft+1);

  logic [CntW-1:0] rows;
  logic            ovf;
  logic            acc;
  logic            full;

  assign full        = (rows == CntW'(MaxLeft));
  assign in_ch.ready = !job_valid;
  assign acc         = in_ch.valid && in_ch.ready;
  assign row_we      = acc && !full;
  assign row_addr    = rows[$clog2(MaxLeft)-1:0];
  assign row_data    = in_ch.data.row_bits;

  // count rows, hand one job per last row
  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= '0;
      ovf       <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        job_valid <= 1'b0;
      end
      if (acc) begin
        if (in_ch.data.last_row) begin
          job_valid <= 1'b1;
          job_rows  <= full ? rows : rows + CntW'(1);
          job_ovf   <= ovf || full;
          rows      <= '0;
          ovf       <= 1'b0;
        end else if (full) begin
          ovf <= 1'b1;
        end else begin
          rows <= rows + CntW'(1);
        end
      end
    end
  end

  `ASSERT_NEVER(a_rows_bound, clk, rst, rows > CntW'(MaxLeft))
  `ASSERT_IMPL(a_job_hold, clk, rst, job_valid && !job_ready |=> job_valid)
  `ASSERT_NEVER(a_no_acc_busy, clk, rst, acc && job_valid)
endmodule

FILE: rtl/bmm_back.sv
`include "assert_macros.svh"
module bmm_back #(
  parameter int MaxLeft  = bmm_pkg::DefMaxLeft,
  parameter int MaxRight = bmm_pkg::DefMaxRight
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bmm_pkg::RcW-1:0]      right_count,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  logic [$clog2(MaxLeft+1)-1:0] job_rows,
  input  logic                         job_ovf,
  output logic [$clog2(MaxLeft)-1:0]   row_raddr,
  input  logic [bmm_pkg::RowW-1:0]     row_rdata,
  bmm_out_if.source                    out_ch
);
  import bmm_pkg::*;
  localparam int LW   = $clog2(MaxLeft);
  localparam int CntW = $clog2(MaxLeft+1);
  localparam int RW   = $clog2(MaxRight);
  localparam int SW   = $clog2(MaxRight+2);
  localparam int SAW  = $clog2(MaxRight+1);
  localparam int FW   = LW + RW;

  bk_state_t state, state_next;

  // partner valid bit per right vertex, left index kept in a ram
  logic [MaxRight-1:0] pvalid;
  logic                part_we;
  logic [RW-1:0]       part_waddr;
  logic [LW-1:0]       part_wdata;
  logic [LW-1:0]       part_rdata;
  // search stack frames in a ram: left vertex and right vertex it was reached through
  logic                stk_we;
  logic [SAW-1:0]      stk_waddr;
  logic [SAW-1:0]      stk_raddr;
  logic [FW-1:0]       stk_wdata;
  logic [FW-1:0]       stk_rdata;
  logic [SW-1:0]       sp;
  logic [63:0]         visited;
  logic [63:0]         adj;
  logic [CntW-1:0]     nrows;
  logic                ovf;
  logic [CntW-1:0]     cur;
  logic [MatchW-1:0]   match_cnt;
  logic [RcW-1:0]      nr;
  logic [63:0]         rmask;
  logic [63:0]         cand;
  logic [RW-1:0]       pick;
  logic [RW-1:0]       pick_q;
  logic [RW-1:0]       uvia;
  logic                found;
  logic                free_hit;
  logic [SW-1:0]       top;
  logic [SW-1:0]       below;
  logic [LW-1:0]       cur_left;

  assign nr    = (right_count > RcW'(MaxRight)) ? RcW'(MaxRight) : right_count;
  assign rmask = (nr >= RcW'(64)) ? '1 : ((64'd1 << nr) - 64'd1);
  assign cand  = adj & ~visited;
  assign top   = sp - SW'(1);
  assign below = sp - SW'(2);

  // lowest unvisited neighbour of the top frame
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int j = MaxRight-1; j >= 0; j--) begin
      if (cand[j]) begin
        pick  = RW'(j);
        found = 1'b1;
      end
    end
  end

  assign free_hit  = (state == S_SCAN) && found && !pvalid[pick];
  assign row_raddr = cur_left;
  // job leaves the queue only once its result is out, so the row store is free
  assign job_ready = (state == S_CLR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (job_valid) state_next = S_START;
      S_START:  state_next = (cur == nrows) ? S_DONE : S_RD;
      S_RD:     state_next = S_WAIT;
      S_WAIT:   state_next = S_SCAN;
      S_SCAN: begin
        if (!found) state_next = (sp == SW'(1)) ? S_START : S_POP;
        else if (!pvalid[pick]) state_next = (sp == SW'(1)) ? S_START : S_UNRD;
        else state_next = S_PUSH;
      end
      S_PUSH:   state_next = S_RD;
      S_POP:    state_next = S_RD;
      S_UNRD:   state_next = S_UNWIND;
      S_UNWIND: if (sp == SW'(1)) state_next = S_START;
      S_DONE:   if (out_ch.ready) state_next = S_CLR;
      S_CLR:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and ram controls
  always_comb begin
    out_ch.valid = (state == S_DONE);
    out_ch.data.match_count = match_cnt;
    out_ch.data.independent_count =
      IndW'(IndW'(nrows) + IndW'(nr) - IndW'(match_cnt));
    out_ch.data.overflow = ovf;

    part_we    = free_hit || (state == S_UNWIND);
    part_waddr = (state == S_UNWIND) ? uvia : pick;
    part_wdata = (state == S_UNWIND) ? stk_rdata[FW-1:RW] : cur_left;

    stk_we    = (state == S_START) || (state == S_PUSH);
    stk_waddr = (state == S_START) ? '0 : sp[SAW-1:0];
    stk_wdata = (state == S_START) ? {cur[LW-1:0], {RW{1'b0}}} : {part_rdata, pick_q};
    stk_raddr = free_hit ? top[SAW-1:0] : below[SAW-1:0];
  end

  bmm_ram #(.Width(LW), .Depth(MaxRight)) u_part (
    .clk, .we(part_we), .waddr(part_waddr), .wdata(part_wdata),
    .raddr(pick), .rdata(part_rdata)
  );

  bmm_ram #(.Width(FW), .Depth(MaxRight+1)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // search datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pvalid <= '0;
      sp     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: if (job_valid) begin
          nrows     <= job_rows;
          ovf       <= job_ovf;
          cur       <= '0;
          match_cnt <= '0;
          pvalid    <= '0;
        end
        S_START: begin
          sp       <= SW'(1);
          visited  <= '0;
          cur_left <= cur[LW-1:0];
        end
        S_WAIT: adj <= row_rdata & rmask;
        S_SCAN: begin
          pick_q <= pick;
          if (!found) begin
            if (sp == SW'(1)) cur <= cur + CntW'(1);
            else sp <= top;
          end else begin
            visited[pick] <= 1'b1;
            if (!pvalid[pick]) begin
              pvalid[pick] <= 1'b1;
              if (sp == SW'(1)) begin
                match_cnt <= match_cnt + MatchW'(1);
                cur       <= cur + CntW'(1);
              end
            end
          end
        end
        // new frame for the left vertex holding the picked right vertex
        S_PUSH: begin
          cur_left <= part_rdata;
          sp       <= sp + SW'(1);
        end
        // back to the parent frame
        S_POP: cur_left <= stk_rdata[FW-1:RW];
        S_UNRD: begin
          uvia <= stk_rdata[RW-1:0];
          sp   <= top;
        end
        // flip the path one frame per cycle
        S_UNWIND: begin
          uvia <= stk_rdata[RW-1:0];
          if (sp == SW'(1)) begin
            match_cnt <= match_cnt + MatchW'(1);
            cur       <= cur + CntW'(1);
          end else begin
            sp <= top;
          end
        end
        S_CLR: pvalid <= '0;
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_sp_bound, clk, rst, sp > SW'(MaxRight+1) && state != S_IDLE)
  `ASSERT_IMPL(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready |=> out_ch.valid)
  `ASSERT_NEVER(a_match_bound, clk, rst, state == S_DONE && 32'(match_cnt) > 32'(nrows))
endmodule

FILE: rtl/bipartite_max_matching_core.sv
// bipartite_max_matching_core: maximum bipartite matching by augmenting paths
// in_ch carries one left-vertex adjacency row (row_bits) per transfer;
// last_row marks the final row and starts the search over all stored rows.
// out_ch gives one result per last row: match_count, independent_count
// (rows + right count - matches) and overflow (rows past the store dropped).
// right_count is to be written by the user through cfg_we/cfg_data only
// while the block is idle; the block itself does not enforce this.
// row loads go on without a pause until the final row hands a job to the
// search engine. per left vertex the engine starts a search, scans each
// stack frame by a row read, a wait and a scan, pushes or pops frames as
// it goes, and flips a found augmenting path by unwinding the stack frame
// by frame. the input stalls from the cycle after a last row until the
// search engine is idle again, which it reaches through a clear state
// after the result transfer. the result stays on out_ch until taken; a
// stalled receiver holds the search engine and with it the input.
// reset (rst, synchronous) clears counters, flags and right_count; the
// row store needs no clearing since only written rows are read.
module bipartite_max_matching_core #(
  parameter int MaxLeft  = bmm_pkg::DefMaxLeft,
  parameter int MaxRight = bmm_pkg::DefMaxRight
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [bmm_pkg::RcW-1:0] cfg_data,
  bmm_in_if.sink                  in_ch,
  bmm_out_if.source               out_ch
);
  import bmm_pkg::*;
  localparam int LW   = $clog2(MaxLeft);
  localparam int CntW = $clog2(MaxLeft+1);

  logic [RcW-1:0]  right_count;
  logic            row_we;
  logic [LW-1:0]   row_addr, row_raddr;
  logic [RowW-1:0] row_data, row_rdata;
  logic            job_valid, job_ready, job_ovf;
  logic [CntW-1:0] job_rows;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      right_count <= '0;
    end else if (cfg_we) begin
      right_count <= cfg_data;
    end
  end

  bmm_front #(.MaxLeft(MaxLeft)) u_front (
    .clk, .rst, .in_ch, .row_we, .row_addr, .row_data,
    .job_valid, .job_ready, .job_rows, .job_ovf
  );

  bmm_ram #(.Width(RowW), .Depth(MaxLeft)) u_rows (
    .clk, .we(row_we), .waddr(row_addr), .wdata(row_data),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  bmm_back #(.MaxLeft(MaxLeft), .MaxRight(MaxRight)) u_back (
    .clk, .rst, .right_count, .job_valid, .job_ready, .job_rows, .job_ovf,
    .row_raddr, .row_rdata, .out_ch
  );
endmodule
